[rtl/sil_pkg.sv]
// shared constants and types for the sorted insert list
package sil_pkg;

	localparam int LIST_DEPTH_DEF   = 32;
	localparam int VEHICLE_BITS_DEF = 8;
	localparam int HANDLE_BITS_DEF  = 16;

	// fixed field widths on the stream ports
	localparam int MODE_W     = 2;
	localparam int VEH_FIELD_W = 8;
	localparam int COST_W     = 32;
	localparam int HDL_FIELD_W = 16;
	localparam int POS_W      = 5;
	localparam int CNT_FIELD_W = 6;
	localparam int STAT_W     = 2;

	localparam int IN_BITS  = MODE_W + VEH_FIELD_W + COST_W + HDL_FIELD_W + POS_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + CNT_FIELD_W + STAT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd2;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic             insert_en;
		logic             erase_en;
		logic [POS_W-1:0] pos;
		logic [COST_W-1:0] cost;
	} cell_cmd_t;

endpackage

[rtl/sil_cell.sv]
// one list slot: holds an entry and shifts toward either neighbor
module sil_cell #(
	parameter int IDX          = 0,
	parameter int CNT_W        = 6,
	parameter int VEHICLE_BITS = 8,
	parameter int HANDLE_BITS  = 16
) (
	input  logic                          clk,
	input  sil_pkg::cell_cmd_t            cmd,
	input  logic [CNT_W-1:0]              count,
	input  logic [VEHICLE_BITS-1:0]       new_vehicle,
	input  logic [HANDLE_BITS-1:0]        new_handle,
	input  logic                          left_keep,
	input  logic [VEHICLE_BITS-1:0]       left_vehicle,
	input  logic [sil_pkg::COST_W-1:0]    left_cost,
	input  logic [HANDLE_BITS-1:0]        left_handle,
	input  logic [VEHICLE_BITS-1:0]       right_vehicle,
	input  logic [sil_pkg::COST_W-1:0]    right_cost,
	input  logic [HANDLE_BITS-1:0]        right_handle,
	input  logic [VEHICLE_BITS-1:0]       query_vehicle,
	output logic                          keep,
	output logic                          match,
	output logic [VEHICLE_BITS-1:0]       vehicle,
	output logic [sil_pkg::COST_W-1:0]    cost,
	output logic [HANDLE_BITS-1:0]        handle
);
	import sil_pkg::*;

	logic [VEHICLE_BITS-1:0] vehicle_q;
	logic [COST_W-1:0]       cost_q;
	logic [HANDLE_BITS-1:0]  handle_q;
	logic                    occ;
	logic                    take_new;
	logic                    take_left;
	logic                    take_right;

	assign occ  = IDX < 32'(count);
	// stays put when its cost is not above the new one: ties keep arrival order
	assign keep = occ && ($signed(cost_q) <= $signed(cmd.cost));

	assign take_new   = cmd.insert_en && !keep && ((IDX == 0) || left_keep);
	assign take_left  = cmd.insert_en && !keep && (IDX != 0) && !left_keep;
	assign take_right = cmd.erase_en && (32'(cmd.pos) <= IDX);

	always_ff @(posedge clk) begin
		if (take_new) begin
			vehicle_q <= new_vehicle;
			cost_q    <= cmd.cost;
			handle_q  <= new_handle;
		end else if (take_left) begin
			vehicle_q <= left_vehicle;
			cost_q    <= left_cost;
			handle_q  <= left_handle;
		end else if (take_right) begin
			vehicle_q <= right_vehicle;
			cost_q    <= right_cost;
			handle_q  <= right_handle;
		end
	end

	assign match   = occ && (vehicle_q == query_vehicle);
	assign vehicle = vehicle_q;
	assign cost    = cost_q;
	assign handle  = handle_q;

endmodule

[rtl/sorted_insert_list_core.sv]
// top level of the sorted insert list: cell chain, count and result staging
//
// The block keeps up to LIST_DEPTH entries (vehicle, signed cost, handle) in a
// row of cells sorted by ascending cost. Each cell compares its own cost with
// the incoming one, so an insert finds its slot and shifts the tail by one at
// the edge that accepts it; an erase shifts every cell at or after the position
// down by one, also at that edge. One item is taken per clock when the output side
// keeps up. An item updates the cells at its accept edge; in the next cycle the
// cells are searched for the vehicle number, which sets the present flag, and
// the result lands in the output register once it is free. Output valid rises
// when that register is loaded, after the search stage register. Inserts into a
// full list are dropped with status 1, erases at a position not below the count
// are dropped with status 2, and a query or any other mode only reports
// presence and count.
module sorted_insert_list_core #(
	parameter int LIST_DEPTH   = sil_pkg::LIST_DEPTH_DEF,
	parameter int VEHICLE_BITS = sil_pkg::VEHICLE_BITS_DEF,
	parameter int HANDLE_BITS  = sil_pkg::HANDLE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// mode[1:0], vehicle[9:2], cost[41:10], handle[57:42], position[62:58]
	input  logic [sil_pkg::IN_W-1:0]  s_tdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// present[0], entry_count[6:1], status[8:7]
	output logic [sil_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready
);
	import sil_pkg::*;

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// input field unpacking
	logic [MODE_W-1:0]      in_mode;
	logic [VEH_FIELD_W-1:0] in_vehicle;
	logic [COST_W-1:0]      in_cost;
	logic [HDL_FIELD_W-1:0] in_handle;
	logic [POS_W-1:0]       in_pos;

	assign in_mode    = s_tdata[MODE_W-1:0];
	assign in_vehicle = s_tdata[MODE_W +: VEH_FIELD_W];
	assign in_cost    = s_tdata[MODE_W+VEH_FIELD_W +: COST_W];
	assign in_handle  = s_tdata[MODE_W+VEH_FIELD_W+COST_W +: HDL_FIELD_W];
	assign in_pos     = s_tdata[MODE_W+VEH_FIELD_W+COST_W+HDL_FIELD_W +: POS_W];

	// vehicle and handle fitted to the stored widths (zero-extend, then mask)
	logic [VEH_FIELD_W+31:0] veh_ext;
	logic [HDL_FIELD_W+31:0] hdl_ext;
	logic [VEHICLE_BITS-1:0] veh_m;
	logic [HANDLE_BITS-1:0]  hdl_m;

	assign veh_ext = {32'd0, in_vehicle};
	assign hdl_ext = {32'd0, in_handle};
	assign veh_m   = veh_ext[VEHICLE_BITS-1:0];
	assign hdl_m   = hdl_ext[HANDLE_BITS-1:0];

	// control registers
	logic [CNT_W-1:0]        count_q;
	logic                    valid_s1;
	logic [VEHICLE_BITS-1:0] query_s1;
	logic [STAT_W-1:0]       status_s1;
	logic                    present_q;
	logic [CNT_W-1:0]        count_out_q;
	logic [STAT_W-1:0]       status_q;
	logic                    out_valid_q;

	logic out_free;
	logic in_xfer;
	logic full;
	logic pos_ok;
	logic do_insert;
	logic do_erase;
	logic [STAT_W-1:0] status_d;
	cell_cmd_t cmd;

	// the search stage must drain before the cells change again
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;
	assign in_xfer  = s_tvalid && s_tready;

	assign full      = count_q == CNT_W'(LIST_DEPTH);
	assign pos_ok    = CMP_W'(in_pos) < CMP_W'(count_q);
	assign do_insert = in_xfer && (in_mode == MODE_INSERT) && !full;
	assign do_erase  = in_xfer && (in_mode == MODE_ERASE) && pos_ok;

	always_comb begin
		case (in_mode)
			MODE_INSERT: status_d = full ? STAT_FULL : STAT_DONE;
			MODE_ERASE:  status_d = pos_ok ? STAT_DONE : STAT_BAD_POS;
			default:     status_d = STAT_DONE;
		endcase
	end

	assign cmd.insert_en = do_insert;
	assign cmd.erase_en  = do_erase;
	assign cmd.pos       = in_pos;
	assign cmd.cost      = in_cost;

	// cell chain
	logic [LIST_DEPTH-1:0]   keep_c;
	logic [LIST_DEPTH-1:0]   match_c;
	logic [VEHICLE_BITS-1:0] veh_c [LIST_DEPTH];
	logic [COST_W-1:0]       cost_c [LIST_DEPTH];
	logic [HANDLE_BITS-1:0]  hdl_c [LIST_DEPTH];

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		localparam int L = (i == 0) ? 0 : i - 1;
		localparam int R = (i == LIST_DEPTH - 1) ? i : i + 1;

		sil_cell #(
			.IDX          (i),
			.CNT_W        (CNT_W),
			.VEHICLE_BITS (VEHICLE_BITS),
			.HANDLE_BITS  (HANDLE_BITS)
		) u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.count         (count_q),
			.new_vehicle   (veh_m),
			.new_handle    (hdl_m),
			.left_keep     (keep_c[L]),
			.left_vehicle  (veh_c[L]),
			.left_cost     (cost_c[L]),
			.left_handle   (hdl_c[L]),
			.right_vehicle (veh_c[R]),
			.right_cost    (cost_c[R]),
			.right_handle  (hdl_c[R]),
			.query_vehicle (query_s1),
			.keep          (keep_c[i]),
			.match         (match_c[i]),
			.vehicle       (veh_c[i]),
			.cost          (cost_c[i]),
			.handle        (hdl_c[i])
		);
	end

	// entry count and search stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			valid_s1  <= 1'b0;
			status_s1 <= STAT_DONE;
			query_s1  <= '0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_erase) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (in_xfer) begin
				valid_s1  <= 1'b1;
				query_s1  <= veh_m;
				status_s1 <= status_d;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// output register: presence is read from the cells as they stand after the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			present_q   <= 1'b0;
			count_out_q <= '0;
			status_q    <= STAT_DONE;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				present_q   <= |match_c;
				count_out_q <= count_q;
				status_q    <= status_s1;
			end
		end
	end

	logic [CNT_W+CNT_FIELD_W-1:0] cnt_ext;
	assign cnt_ext = {{CNT_FIELD_W{1'b0}}, count_out_q};

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W-OUT_BITS){1'b0}}, status_q, cnt_ext[CNT_FIELD_W-1:0], present_q};

endmodule
